// ===== rtl/pds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, register indexes and lane arithmetic for the 2x2 downscaler.
// ----------------------------------------------------------------------------
package pds_pkg;

	localparam int CH_W   = 8;   // input / output channel
	localparam int QTR_W  = 6;   // quartered channel
	localparam int PAIR_W = 7;   // sum of two quarters
	localparam int CFG_W  = 12;  // configuration data

	localparam int QTRS_W = 3 * QTR_W;
	localparam int PAIRS_W = 3 * PAIR_W;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IDX_WIDTH  = 1'b0;
	localparam cfg_idx_t CFG_IDX_HEIGHT = 1'b1;

	typedef logic [QTRS_W-1:0]  qtrs_t;
	typedef logic [PAIRS_W-1:0] pairs_t;

	// per-position control handed from the position counters to the datapath
	typedef struct packed {
		logic store_wr;  // odd column of an even row
		logic store_rd;  // odd column of an odd row
		logic even_col;
		logic last;      // final output position of the frame
	} pos_t;

	function automatic qtrs_t quarter(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
		input logic [CH_W-1:0] r);
		quarter = {r[CH_W-1:2], g[CH_W-1:2], b[CH_W-1:2]};
	endfunction

	function automatic pairs_t pair_add(input qtrs_t a, input qtrs_t b);
		pairs_t res;
		for (int k = 0; k < 3; k++) begin
			res[k*PAIR_W +: PAIR_W] = PAIR_W'(a[k*QTR_W +: QTR_W]) +
				PAIR_W'(b[k*QTR_W +: QTR_W]);
		end
		pair_add = res;
	endfunction

	function automatic logic [3*CH_W-1:0] total_add(input pairs_t a, input pairs_t b);
		logic [3*CH_W-1:0] res;
		for (int k = 0; k < 3; k++) begin
			res[k*CH_W +: CH_W] = CH_W'(a[k*PAIR_W +: PAIR_W]) +
				CH_W'(b[k*PAIR_W +: PAIR_W]);
		end
		total_add = res;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pixel_downscale_2x2_average_top.sv =====
// ----------------------------------------------------------------------------
// pixel_downscale_2x2_average_top: 2x2 box downscale of a BGR pixel stream
// One word per cycle in while in_stall is low; a result passes through the line store
// read register and stage 1, then through the output register, before it leaves.
// Async reset: sizes to 2, positions to 0; line store contents undefined.
// ----------------------------------------------------------------------------
`default_nettype none
module pixel_downscale_2x2_average_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire pds_pkg::cfg_idx_t          cfg_index,
	input  wire logic [pds_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output      logic                       in_stall,
	input  wire logic [pds_pkg::CH_W-1:0]   in_blue,
	input  wire logic [pds_pkg::CH_W-1:0]   in_green,
	input  wire logic [pds_pkg::CH_W-1:0]   in_red,
	output      logic                       out_valid,
	input  wire logic                       out_stall,
	output      logic [pds_pkg::CH_W-1:0]   out_blue,
	output      logic [pds_pkg::CH_W-1:0]   out_green,
	output      logic [pds_pkg::CH_W-1:0]   out_red,
	output      logic                       last_in_frame
);

	localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 2;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = pds_pkg::CH_W;

	pds_pkg::pos_t   pos;
	logic [AW-1:0]   pair_idx;
	logic            in_acc, rd_issue, wr_issue, adv;
	pds_pkg::qtrs_t  qtrs, left_q;
	pds_pkg::pairs_t pair, rd_data, pair_s1;
	logic            v_s1, last_s1;
	logic [3*CW-1:0] total, total_q;
	logic            out_valid_q, last_q;

	pds_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_acc),
		.pos       (pos),
		.pair_idx  (pair_idx)
	);

	pds_line_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_issue),
		.wr_addr (pair_idx),
		.wr_data (pair),
		.rd_en   (rd_issue),
		.rd_addr (pair_idx),
		.rd_data (rd_data)
	);

	// stage 1 can only be blocked by a full, stalled output register
	assign in_stall = v_s1 & out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;
	assign wr_issue = in_acc & pos.store_wr;
	assign rd_issue = in_acc & pos.store_rd;
	assign adv      = v_s1 & (~out_valid_q | ~out_stall);

	always_comb begin
		qtrs  = pds_pkg::quarter(in_blue, in_green, in_red);
		pair  = pds_pkg::pair_add(left_q, qtrs);
		total = pds_pkg::total_add(rd_data, pair_s1);
	end

	always_ff @(posedge clk) begin
		if (in_acc && pos.even_col) begin
			left_q <= qtrs;
		end
		if (rd_issue) begin
			pair_s1 <= pair;
			last_s1 <= pos.last;
		end
		if (adv) begin
			total_q <= total;
			last_q  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_issue)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_blue      = total_q[0 +: CW];
	assign out_green     = total_q[CW +: CW];
	assign out_red       = total_q[2*CW +: CW];
	assign last_in_frame = last_q;

`ifndef SYNTHESIS
	a_read_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rd_issue |=> v_s1)
		else $error("read issued but stage 1 empty");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && out_stall) |=> (v_s1 && $stable(pair_s1)))
		else $error("blocked stage 1 word lost");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_issue && rd_issue))
		else $error("line store read and write in one cycle");
`endif

endmodule
`default_nettype wire

// ===== rtl/pds_line_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_line_store
// Single-port-write, single-port-read line memory with registered read data.
// ----------------------------------------------------------------------------
module pds_line_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_addr,
	input  wire pds_pkg::pairs_t           wr_data,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	output      pds_pkg::pairs_t           rd_data
);

	pds_pkg::pairs_t mem [DEPTH];
	pds_pkg::pairs_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/pds_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pds_ctrl
// Size registers and raster position counters; decodes what each word does.
// ----------------------------------------------------------------------------
module pds_ctrl #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int AW         = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire pds_pkg::cfg_idx_t          cfg_index,
	input  wire logic [pds_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       advance,
	output      pds_pkg::pos_t              pos,
	output      logic [AW-1:0]              pair_idx
);

	// a 12-bit register can never exceed 4095
	localparam int WMAX = (MAX_WIDTH  < 4095) ? MAX_WIDTH  : 4095;
	localparam int HMAX = (MAX_HEIGHT < 4095) ? MAX_HEIGHT : 4095;
	localparam int WB = $clog2(WMAX + 1);
	localparam int HB = $clog2(HMAX + 1);
	localparam int CB = (WMAX > 2) ? $clog2(WMAX) : 1;
	localparam int RB = (HMAX > 2) ? $clog2(HMAX) : 1;

	logic [WB-1:0] width_q;
	logic [HB-1:0] height_q;
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;

	logic [WB:0] col_p1, col_p2, w_ext;
	logic [HB:0] row_p1, row_p2, h_ext;
	logic        col_end, row_end, col_last, row_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WB'(2);
			height_q <= HB'(2);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_write) begin
			// any register write restarts the frame
			col_q <= '0;
			row_q <= '0;
			case (cfg_index)
				pds_pkg::CFG_IDX_WIDTH: begin
					if (cfg_data < pds_pkg::CFG_W'(2))
						width_q <= WB'(2);
					else if (int'(cfg_data) > WMAX)
						width_q <= WB'(WMAX);
					else
						width_q <= WB'(cfg_data);
				end
				pds_pkg::CFG_IDX_HEIGHT: begin
					if (cfg_data < pds_pkg::CFG_W'(2))
						height_q <= HB'(2);
					else if (int'(cfg_data) > HMAX)
						height_q <= HB'(HMAX);
					else
						height_q <= HB'(cfg_data);
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : RB'(row_p1);
			end else begin
				col_q <= CB'(col_p1);
			end
		end
	end

	always_comb begin
		w_ext  = (WB+1)'(width_q);
		h_ext  = (HB+1)'(height_q);
		col_p1 = (WB+1)'(col_q) + (WB+1)'(1);
		col_p2 = (WB+1)'(col_q) + (WB+1)'(2);
		row_p1 = (HB+1)'(row_q) + (HB+1)'(1);
		row_p2 = (HB+1)'(row_q) + (HB+1)'(2);
		col_end = (col_p1 == w_ext);
		row_end = (row_p1 == h_ext);
		// an odd position is last of the even-trimmed extent when one or two short
		col_last = col_end || (col_p2 == w_ext);
		row_last = row_end || (row_p2 == h_ext);
	end

	always_comb begin
		pos.even_col = ~col_q[0];
		pos.store_wr = col_q[0] & ~row_q[0];
		pos.store_rd = col_q[0] & row_q[0];
		pos.last     = col_last & row_last;
		pair_idx     = AW'(col_q >> 1);
	end

endmodule
`default_nettype wire

// ===== tb/tb_pixel_downscale_2x2_average_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_downscale_2x2_average_top
// Drives BGR pixel words in raster order through the 2x2 downscaler and checks
// each output word against a cycle-free model of the box average. The run starts
// with a short scripted table: extremes, odd sizes and clamped sizes. Then come
// cut-off frames at the clamped largest sizes, and after them random frames and
// cut-off frames. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_pixel_downscale_2x2_average_top;

	localparam int MAX_W         = 2048;
	localparam int MAX_H         = 2048;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 330;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SCRIPT_LEN    = 29;

	typedef struct packed {
		logic [pds_pkg::CH_W-1:0] blue;
		logic [pds_pkg::CH_W-1:0] green;
		logic [pds_pkg::CH_W-1:0] red;
		logic                     last;
	} pix_out_t;

	typedef enum logic {ROW_PIXEL, ROW_SETUP} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		pds_pkg::cfg_idx_t         reg_sel;
		logic [pds_pkg::CFG_W-1:0] reg_val;
		logic [pds_pkg::CH_W-1:0]  blue;
		logic [pds_pkg::CH_W-1:0]  green;
		logic [pds_pkg::CH_W-1:0]  red;
		logic                      typed;
		pix_out_t                  want;
	} script_row_t;

	localparam pix_out_t NO_RESULT = '0;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_write;
	pds_pkg::cfg_idx_t         cfg_index;
	logic [pds_pkg::CFG_W-1:0] cfg_data;
	logic                      in_valid;
	logic                      in_stall;
	logic [pds_pkg::CH_W-1:0]  in_blue;
	logic [pds_pkg::CH_W-1:0]  in_green;
	logic [pds_pkg::CH_W-1:0]  in_red;
	logic                      out_valid;
	logic                      out_stall;
	logic [pds_pkg::CH_W-1:0]  out_blue;
	logic [pds_pkg::CH_W-1:0]  out_green;
	logic [pds_pkg::CH_W-1:0]  out_red;
	logic                      last_in_frame;

	// downscale model state
	logic [pds_pkg::CFG_W-1:0] width_reg  = 12'd2;
	logic [pds_pkg::CFG_W-1:0] height_reg = 12'd2;
	logic [5:0]          left_qtr [3];
	logic [6:0]          pair_store [MAX_W/2][3];
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;

	pix_out_t            pending_pixels [$];
	int                  fail_count = 0;
	int                  cycle_count = 0;
	bit                  calm = 1'b0;

	script_row_t script [SCRIPT_LEN] = '{
		// reset sizes 2x2: all-zero block, all-max block, truncation per channel
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   1'b1,
			'{8'd0, 8'd0, 8'd0, 1'b1}},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b1,
			'{8'd252, 8'd252, 8'd252, 1'b1}},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd3,   8'd4,   8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd3,   8'd4,   8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd3,   8'd4,   8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd3,   8'd4,   8'd255, 1'b1,
			'{8'd0, 8'd4, 8'd252, 1'b1}},
		// sizes below the minimum act as 2
		'{ROW_SETUP, pds_pkg::CFG_IDX_WIDTH,  12'd0, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
		'{ROW_SETUP, pds_pkg::CFG_IDX_HEIGHT, 12'd1, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd17,  8'd200, 8'd96,  1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd0,   8'd128, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd1,   8'd2,   8'd254, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd64,  8'd191, 8'd7,   1'b0, NO_RESULT},
		// 3x3: trailing column and trailing row are dropped
		'{ROW_SETUP, pds_pkg::CFG_IDX_WIDTH,  12'd3, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
		'{ROW_SETUP, pds_pkg::CFG_IDX_HEIGHT, 12'd3, 8'd0, 8'd0, 8'd0, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd0,   8'd255, 8'd0,   1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd0,   8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd9,   8'd9,   8'd9,   1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd100, 8'd50,  8'd25,  1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd128, 8'd64,  8'd32,  1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd77,  8'd77,  8'd77,  1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd255, 8'd255, 8'd255, 1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd0,   8'd0,   8'd0,   1'b0, NO_RESULT},
		'{ROW_PIXEL, pds_pkg::CFG_IDX_WIDTH, 12'd0, 8'd12,  8'd34,  8'd56,  1'b0, NO_RESULT}
	};

	pixel_downscale_2x2_average_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_blue       (in_blue),
		.in_green      (in_green),
		.in_red        (in_red),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_blue      (out_blue),
		.out_green     (out_green),
		.out_red       (out_red),
		.last_in_frame (last_in_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_size(input logic [pds_pkg::CFG_W-1:0] v,
		input int unsigned top);
		if (v < 2)
			return 2;
		if (v > top)
			return top;
		return 32'(v);
	endfunction

	// One pixel through the box average; returns 1 when it completes a block.
	function automatic bit predict_downscale(input logic [pds_pkg::CH_W-1:0] b,
		input logic [pds_pkg::CH_W-1:0] g, input logic [pds_pkg::CH_W-1:0] r,
		output pix_out_t res);
		logic [5:0]  qtr [3];
		logic [6:0]  pair [3];
		int unsigned w;
		int unsigned h;
		int unsigned even_w;
		int unsigned even_h;
		int unsigned slot;
		bit          made;
		made   = 1'b0;
		res    = '0;
		w      = clamp_size(width_reg, MAX_W);
		h      = clamp_size(height_reg, MAX_H);
		even_w = w - (w % 2);
		even_h = h - (h % 2);
		slot   = col_pos / 2;
		qtr[0] = b[7:2];
		qtr[1] = g[7:2];
		qtr[2] = r[7:2];
		if (col_pos % 2 == 0) begin
			for (int k = 0; k < 3; k++)
				left_qtr[k] = qtr[k];
		end else if (col_pos < even_w) begin
			for (int k = 0; k < 3; k++)
				pair[k] = {1'b0, left_qtr[k]} + {1'b0, qtr[k]};
			if (row_pos % 2 == 0) begin
				for (int k = 0; k < 3; k++)
					pair_store[slot][k] = pair[k];
			end else if (row_pos < even_h) begin
				res.blue  = {1'b0, pair_store[slot][0]} + {1'b0, pair[0]};
				res.green = {1'b0, pair_store[slot][1]} + {1'b0, pair[1]};
				res.red   = {1'b0, pair_store[slot][2]} + {1'b0, pair[2]};
				res.last  = (row_pos == even_h - 1) && (col_pos == even_w - 1);
				made      = 1'b1;
			end
		end
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return made;
	endfunction

	function automatic logic [pds_pkg::CH_W-1:0] rand_channel();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return pds_pkg::CH_W'($urandom_range(0, 255));
	endfunction

	// now and then a size below the minimum
	function automatic logic [pds_pkg::CFG_W-1:0] rand_size(input int unsigned top);
		if ($urandom_range(0, 7) == 0)
			return pds_pkg::CFG_W'($urandom_range(0, 1));
		return pds_pkg::CFG_W'($urandom_range(2, top));
	endfunction

	// Stop sending, wait for every expected word, then let the pipe empty of
	// words that make no result.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input pds_pkg::cfg_idx_t sel,
		input logic [pds_pkg::CFG_W-1:0] val);
		drain();
		cfg_write <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		if (sel == pds_pkg::CFG_IDX_WIDTH)
			width_reg = val;
		else
			height_reg = val;
		col_pos = 0;
		row_pos = 0;
		cfg_write <= 1'b0;
	endtask

	task automatic push_pixel(input logic [pds_pkg::CH_W-1:0] b,
		input logic [pds_pkg::CH_W-1:0] g, input logic [pds_pkg::CH_W-1:0] r,
		input bit typed, input pix_out_t want);
		pix_out_t got;
		bit       made;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_blue  <= b;
		in_green <= g;
		in_red   <= r;
		do
			@(posedge clk);
		while (in_stall);
		made = predict_downscale(b, g, r, got);
		if (typed)
			pending_pixels.push_back(want);
		else if (made)
			pending_pixels.push_back(got);
	endtask

	task automatic send_random_pixels(input int n);
		for (int i = 0; i < n; i++)
			push_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, NO_RESULT);
	endtask

	// output side back-pressure in short bursts
	initial begin
		int burst;
		burst     = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && burst == 0 && $urandom_range(0, 5) == 0)
				burst = $urandom_range(1, 5);
			if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				if (fail_count < 10)
					$display("%0t unexpected output word b=%0d g=%0d r=%0d last=%0d", $realtime,
						out_blue, out_green, out_red, last_in_frame);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (want !== {out_blue, out_green, out_red, last_in_frame}) begin
					if (fail_count < 10)
						$display(
							"%0t mismatch: want b=%0d g=%0d r=%0d l=%0d, got b=%0d g=%0d r=%0d l=%0d",
							$realtime, want.blue, want.green, want.red, want.last,
							out_blue, out_green, out_red, last_in_frame);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int          random_items;
		int unsigned w;
		int unsigned h;
		int          n;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = pds_pkg::CFG_IDX_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_blue   = '0;
		in_green  = '0;
		in_red    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].kind == ROW_SETUP)
				write_reg(script[i].reg_sel, script[i].reg_val);
			else
				push_pixel(script[i].blue, script[i].green, script[i].red, script[i].typed,
					script[i].want);
		end

		// all-ones registers clamp to the maximum: tall frame of narrow lines,
		// then the start of the widest line
		write_reg(pds_pkg::CFG_IDX_WIDTH, 12'd2);
		write_reg(pds_pkg::CFG_IDX_HEIGHT, 12'hFFF);
		send_random_pixels(24);
		write_reg(pds_pkg::CFG_IDX_WIDTH, 12'hFFF);
		write_reg(pds_pkg::CFG_IDX_HEIGHT, 12'd2);
		send_random_pixels(20);

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			calm = (random_items >= RANDOM_ITEMS - 60) || ($urandom_range(0, 3) == 0);
			case (random_items == 0 ? 2 : $urandom_range(0, 2))
				0: write_reg(pds_pkg::CFG_IDX_WIDTH, rand_size(10));
				1: write_reg(pds_pkg::CFG_IDX_HEIGHT, rand_size(6));
				default: begin
					write_reg(pds_pkg::CFG_IDX_WIDTH, rand_size(10));
					write_reg(pds_pkg::CFG_IDX_HEIGHT, rand_size(6));
				end
			endcase
			w = clamp_size(width_reg, MAX_W);
			h = clamp_size(height_reg, MAX_H);
			// whole frames, sometimes followed by a frame cut short
			n = int'($urandom_range(1, 2) * w * h);
			if ($urandom_range(0, 3) == 0)
				n += int'($urandom_range(1, w * h - 1));
			if (n > RANDOM_ITEMS - random_items)
				n = RANDOM_ITEMS - random_items;
			send_random_pixels(n);
			random_items += n;
		end

		drain();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
